[rtl/request_dedup_hash_set_core_macros.svh]
// Assertion macros shared by the checker of the request deduplication set.
`ifndef REQUEST_DEDUP_HASH_SET_CORE_MACROS_SVH
`define REQUEST_DEDUP_HASH_SET_CORE_MACROS_SVH

// Condition and consequence in the same cycle.
`define RDHS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdhs assertion failed");

// Consequence in the cycle after the condition.
`define RDHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdhs assertion failed");

`endif

[rtl/rdhs_pkg.sv]
// Shared types and constants of the request deduplication set.
package rdhs_pkg;

	localparam logic [31:0] FIB_MULT = 32'd2654435761;

	localparam logic [1:0] ST_DUPLICATE = 2'd0;
	localparam logic [1:0] ST_DROPPED   = 2'd1;
	localparam logic [1:0] ST_ACCEPTED  = 2'd2;

	// Request as it travels from the front part to the probe engine.
	typedef struct packed {
		logic [15:0] code_address;
		logic [31:0] window_hash;
		logic        queue_full;
		logic [31:0] mixed;
	} req_t;

endpackage

[rtl/request_dedup_hash_set_core.sv]
// Top level of the request deduplication set: front, queue and probe engine.
//
// Requests enter on the s_ stream: one beat per request carrying the routine
// address, its window hash and the downstream queue-full flag. Each request
// gives exactly one result beat on the m_ stream, in request order: a status
// (duplicate, dropped, accepted) and whether the key was written to the set.
// The front registers the beat, then registers it again with its hash;
// a four entry queue holds the request until the probe engine is free.
// The probe engine reads one slot of the key store per cycle through its
// single registered read port and takes a new request only once the last
// is finished. It probes one slot at low load and up to 2^TABLE_BITS slots
// when the set is full. After reset the engine sweeps the key store, one
// slot per cycle, over all 2^TABLE_BITS slots; requests are taken until
// the front and queue fill, and their results follow once the sweep is
// done.
// When the receiver stalls, the result waits in the output register, the
// engine holds the next finished probe, and the front keeps filling the queue.
module request_dedup_hash_set_core #(
	parameter int TABLE_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] code_address, [47:16] window_hash, [48] queue_full, [55:49] zero
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [2] recorded, [7:3] zero
	output logic [7:0]  m_tdata
);

	logic           req_valid;
	logic           req_ready;
	rdhs_pkg::req_t req;
	logic           q_valid;
	logic           q_ready;
	rdhs_pkg::req_t q_data;
	logic [1:0]     res_status;
	logic           res_recorded;

	rdhs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_address (s_tdata[15:0]),
		.in_hash    (s_tdata[47:16]),
		.in_qfull   (s_tdata[48]),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req)
	);

	rdhs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req_valid),
		.push_ready (req_ready),
		.push_data  (req),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	rdhs_probe #(
		.TABLE_BITS (TABLE_BITS)
	) u_probe (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (q_valid),
		.req_ready    (q_ready),
		.req          (q_data),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_status   (res_status),
		.res_recorded (res_recorded)
	);

	assign m_tdata = {5'b0, res_recorded, res_status};

endmodule

[rtl/rdhs_front.sv]
// Front part: takes request beats and computes the Fibonacci hash of each key.
module rdhs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       in_address,
	input  logic [31:0]       in_hash,
	input  logic              in_qfull,
	output logic              req_valid,
	input  logic              req_ready,
	output rdhs_pkg::req_t    req
);

	logic        v_s1;
	logic [15:0] addr_s1;
	logic [31:0] hash_s1;
	logic        qfull_s1;
	logic        v_s2;
	rdhs_pkg::req_t req_s2;
	logic        adv1;
	logic        adv2;
	logic [31:0] key_x;

	assign adv2     = v_s2 && req_ready;
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign in_ready = !v_s1 || adv1;
	assign key_x    = {16'b0, addr_s1} ^ hash_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_s1  <= in_address;
			hash_s1  <= in_hash;
			qfull_s1 <= in_qfull;
		end
		if (adv1) begin
			req_s2.code_address <= addr_s1;
			req_s2.window_hash  <= hash_s1;
			req_s2.queue_full   <= qfull_s1;
			req_s2.mixed        <= key_x * rdhs_pkg::FIB_MULT;
		end
	end

	assign req_valid = v_s2;
	assign req       = req_s2;

endmodule

[rtl/rdhs_fifo.sv]
// Short queue that decouples the hashing front from the probe engine.
module rdhs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rdhs_pkg::req_t    push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rdhs_pkg::req_t    pop_data
);

	localparam int DEPTH  = 4;
	localparam int PTR_W  = $clog2(DEPTH);

	rdhs_pkg::req_t     store_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != (PTR_W+1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/rdhs_probe.sv]
// Back part: clears the key store, probes it linearly and registers each result.
module rdhs_probe #(
	parameter int TABLE_BITS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rdhs_pkg::req_t    req,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        res_status,
	output logic              res_recorded
);

	localparam int SLOTS = 1 << TABLE_BITS;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE
	} state_t;

	state_t                 state_q;
	logic [48:0]            mem [SLOTS];
	logic [48:0]            rdata_q;
	logic [TABLE_BITS-1:0]  clr_q;
	logic [TABLE_BITS-1:0]  slot_q;
	logic [TABLE_BITS-1:0]  cnt_q;
	logic [15:0]            addr_q;
	logic [31:0]            hash_q;
	logic                   qfull_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic                   rec_q;

	logic                   used;
	logic                   match;
	logic                   done;
	logic                   out_free;
	logic                   finish;
	logic                   advance;
	logic                   take;
	logic                   wr_en;
	logic [TABLE_BITS-1:0]  wr_addr;
	logic [48:0]            wr_data;
	logic [TABLE_BITS-1:0]  rd_addr;

	assign used     = rdata_q[48];
	assign match    = used && rdata_q[47:32] == addr_q && rdata_q[31:0] == hash_q;
	assign done     = !used || match || cnt_q == '1;
	assign out_free = !out_valid_q || res_ready;
	assign finish   = state_q == S_PROBE && done && out_free;
	assign advance  = state_q == S_PROBE && !done;
	assign take     = state_q == S_IDLE && req_valid;
	assign req_ready = state_q == S_IDLE;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = {1'b1, addr_q, hash_q};
		rd_addr = slot_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_addr = req.mixed[31 -: TABLE_BITS];
			end
			S_PROBE: begin
				// An empty slot ends the probe; the key lands there unless the queue is full.
				wr_en = finish && !used && !qfull_q;
				if (advance) begin
					rd_addr = slot_q + 1'b1;
				end
			end
			default: begin
				rd_addr = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			slot_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= rdhs_pkg::ST_DUPLICATE;
			rec_q       <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						slot_q  <= req.mixed[31 -: TABLE_BITS];
						cnt_q   <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (advance) begin
						slot_q <= slot_q + 1'b1;
						cnt_q  <= cnt_q + 1'b1;
					end else if (finish) begin
						rec_q <= !used && !qfull_q;
						if (match) begin
							status_q <= rdhs_pkg::ST_DUPLICATE;
						end else if (qfull_q) begin
							status_q <= rdhs_pkg::ST_DROPPED;
						end else begin
							status_q <= rdhs_pkg::ST_ACCEPTED;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q  <= req.code_address;
			hash_q  <= req.window_hash;
			qfull_q <= req.queue_full;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_status   = status_q;
	assign res_recorded = rec_q;

endmodule

[rtl/rdhs_checker.sv]
// Port-level checks of the request deduplication set and their binding.
`include "request_dedup_hash_set_core_macros.svh"

module rdhs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	`RDHS_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] <= rdhs_pkg::ST_ACCEPTED)
	`RDHS_ASSERT_NOW(a_rec_accepted, m_tvalid && m_tdata[2], m_tdata[1:0] == rdhs_pkg::ST_ACCEPTED)
	`RDHS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'b0)
	`RDHS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind request_dedup_hash_set_core rdhs_checker u_rdhs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
